@@ rtl/ambp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Agent message byte parser - shared definitions
// Field widths, status and byte-kind codes, header version and type codes.
// ----------------------------------------------------------------------------
package ambp_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TYPE_W    = 4;
    localparam int unsigned IDLEN_W   = 16;
    localparam int unsigned LEN64_W   = 64;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned KIND_W    = 3;

    // Result beat packing: status, msg_type, byte_out, id_length,
    // payload length, bundle id from bit 0 up, padded to whole bytes
    localparam int unsigned OUT_BITS  = STATUS_W + TYPE_W + BYTE_W + IDLEN_W
                                      + LEN64_W + LEN64_W;
    localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W = OUT_W - OUT_BITS;

    // Header version carried in the high nibble
    localparam logic [3:0] HDR_VERSION = 4'h1;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // What the passed byte is
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 3'd0,
        KIND_IDLEN   = 3'd1,
        KIND_ID      = 3'd2,
        KIND_PLEN    = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_BUNDLE  = 3'd5
    } t_kind;

    // Message type codes
    localparam logic [TYPE_W-1:0] MT_ACK      = 4'h0;
    localparam logic [TYPE_W-1:0] MT_NACK     = 4'h1;
    localparam logic [TYPE_W-1:0] MT_REGISTER = 4'h2;
    localparam logic [TYPE_W-1:0] MT_SEND     = 4'h3;
    localparam logic [TYPE_W-1:0] MT_RECV     = 4'h4;
    localparam logic [TYPE_W-1:0] MT_CONFIRM  = 4'h5;
    localparam logic [TYPE_W-1:0] MT_CANCEL   = 4'h6;
    localparam logic [TYPE_W-1:0] MT_WELCOME  = 4'h7;
    localparam logic [TYPE_W-1:0] MT_PING     = 4'h8;

endpackage

@@ rtl/agent_message_byte_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Agent message byte parser
// Parses a byte stream of agent messages and tags every byte with its role.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw message byte per beat. m_axis returns one result
//   beat per input byte: status (busy, done, error), message type, byte kind,
//   the byte itself and the id length, payload length and bundle id seen so
//   far. i_cfg_we writes the payload length limit (zero disables the check);
//   write it only while no byte is in flight.
//   The result beat is registered and appears in the cycle after its input
//   beat is accepted. One byte per cycle is sustained while the receiver is
//   ready: the phase machine, the 64-bit countdown and the limit compare all
//   resolve in the accept cycle, and the result register takes the outcome.
//   When the receiver stalls, the result register holds its beat and
//   s_axis_tready drops until the beat leaves; a new byte is taken in the
//   same cycle the held beat is taken.
//   Reset clears the limit, all message registers and the result valid; the
//   next byte is parsed as a header. After a done or error result the next
//   byte is again a header.
// ----------------------------------------------------------------------------
module agent_message_byte_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: payload limit
    input  logic                          i_cfg_we,
    input  logic [ambp_pkg::LEN64_W-1:0]  i_cfg_wdata,
    // Input bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ambp_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    // Result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [5:2] msg_type, [13:6] byte_out, [29:14] id_length,
    // [93:30] payload length, [157:94] bundle id, [159:158] zero
    output logic [ambp_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic [ambp_pkg::KIND_W-1:0]   m_axis_tuser    // [2:0] byte_kind
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_IDLEN   = 3'd1,
        PH_ID      = 3'd2,
        PH_PLEN    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_BUNDLE  = 3'd5
    } t_phase;

    localparam logic [2:0] LAST_FIELD_BYTE = 3'd7;

    // Parser state
    t_phase                        r_phase,  n_phase;
    logic [ambp_pkg::TYPE_W-1:0]   r_type,   n_type;
    logic [2:0]                    r_fbc,    n_fbc;
    logic [ambp_pkg::LEN64_W-1:0]  r_acc,    n_acc;
    logic [ambp_pkg::LEN64_W-1:0]  r_rem,    n_rem;
    logic [ambp_pkg::IDLEN_W-1:0]  r_idlen,  n_idlen;
    logic [ambp_pkg::LEN64_W-1:0]  r_plen,   n_plen;
    logic [ambp_pkg::LEN64_W-1:0]  r_bid,    n_bid;
    logic [ambp_pkg::LEN64_W-1:0]  r_limit;

    // Result register
    logic                          r_out_valid;
    ambp_pkg::t_status             r_out_status;
    ambp_pkg::t_kind               r_out_kind;
    logic [ambp_pkg::TYPE_W-1:0]   r_out_type;
    logic [ambp_pkg::BYTE_W-1:0]   r_out_byte;
    logic [ambp_pkg::IDLEN_W-1:0]  r_out_idlen;
    logic [ambp_pkg::LEN64_W-1:0]  r_out_plen;
    logic [ambp_pkg::LEN64_W-1:0]  r_out_bid;

    ambp_pkg::t_status             n_status;
    ambp_pkg::t_kind               n_kind;
    logic                          in_accept;
    logic [ambp_pkg::BYTE_W-1:0]   din;
    logic [ambp_pkg::LEN64_W-1:0]  rem_dec;
    logic                          rem_last;
    logic [ambp_pkg::LEN64_W-1:0]  acc_shift;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign din           = s_axis_tdata;

    // Countdown helpers: saturating decrement, last when at most one left
    assign rem_dec   = (r_rem != '0) ? (r_rem - 64'd1) : '0;
    assign rem_last  = (r_rem[ambp_pkg::LEN64_W-1:1] == '0);
    assign acc_shift = {r_acc[ambp_pkg::LEN64_W-ambp_pkg::BYTE_W-1:0], din};

    // Phase machine: next state and result for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_fbc    = r_fbc;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_idlen  = r_idlen;
        n_plen   = r_plen;
        n_bid    = r_bid;
        n_status = ambp_pkg::ST_BUSY;
        n_kind   = ambp_pkg::KIND_HEADER;

        unique case (r_phase)
            PH_HEADER: begin
                n_fbc   = '0;
                n_acc   = '0;
                n_rem   = '0;
                n_idlen = '0;
                n_plen  = '0;
                n_bid   = '0;
                n_type  = din[3:0];
                if (din[7:4] != ambp_pkg::HDR_VERSION) begin
                    n_status = ambp_pkg::ST_ERR;
                end else begin
                    case (din[3:0]) inside
                        ambp_pkg::MT_ACK, ambp_pkg::MT_NACK, ambp_pkg::MT_PING: begin
                            n_status = ambp_pkg::ST_DONE;
                        end
                        ambp_pkg::MT_REGISTER, ambp_pkg::MT_SEND,
                        ambp_pkg::MT_RECV, ambp_pkg::MT_WELCOME: begin
                            n_phase = PH_IDLEN;
                        end
                        ambp_pkg::MT_CONFIRM, ambp_pkg::MT_CANCEL: begin
                            n_phase = PH_BUNDLE;
                        end
                        default: begin
                            n_status = ambp_pkg::ST_ERR;
                        end
                    endcase
                end
            end
            PH_IDLEN: begin
                n_kind  = ambp_pkg::KIND_IDLEN;
                n_idlen = {r_idlen[ambp_pkg::IDLEN_W-ambp_pkg::BYTE_W-1:0], din};
                if (r_fbc == 3'd0) begin
                    n_fbc = 3'd1;
                end else begin
                    n_fbc = '0;
                    n_rem = {{(ambp_pkg::LEN64_W-ambp_pkg::IDLEN_W){1'b0}}, n_idlen};
                    if (n_idlen == '0) begin
                        n_status = ambp_pkg::ST_DONE;
                    end else begin
                        n_phase = PH_ID;
                    end
                end
            end
            PH_ID: begin
                n_kind = ambp_pkg::KIND_ID;
                n_rem  = rem_dec;
                if (rem_last) begin
                    if (r_type == ambp_pkg::MT_SEND || r_type == ambp_pkg::MT_RECV) begin
                        n_phase = PH_PLEN;
                        n_fbc   = '0;
                        n_acc   = '0;
                    end else begin
                        n_status = ambp_pkg::ST_DONE;
                    end
                end
            end
            PH_PLEN: begin
                n_kind = ambp_pkg::KIND_PLEN;
                n_acc  = acc_shift;
                if (r_fbc != LAST_FIELD_BYTE) begin
                    n_fbc = r_fbc + 3'd1;
                end else begin
                    n_fbc  = '0;
                    n_plen = acc_shift;
                    n_rem  = acc_shift;
                    if (r_limit != '0 && acc_shift > r_limit) begin
                        n_status = ambp_pkg::ST_ERR;
                    end else if (acc_shift == '0) begin
                        n_status = ambp_pkg::ST_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_kind = ambp_pkg::KIND_PAYLOAD;
                n_rem  = rem_dec;
                if (rem_last) begin
                    n_status = ambp_pkg::ST_DONE;
                end
            end
            PH_BUNDLE: begin
                n_kind = ambp_pkg::KIND_BUNDLE;
                n_acc  = acc_shift;
                if (r_fbc != LAST_FIELD_BYTE) begin
                    n_fbc = r_fbc + 3'd1;
                end else begin
                    n_fbc    = '0;
                    n_bid    = acc_shift;
                    n_status = ambp_pkg::ST_DONE;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // Restart at a header after done or error
        if (n_status != ambp_pkg::ST_BUSY) begin
            n_phase = PH_HEADER;
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_type      <= '0;
            r_fbc       <= '0;
            r_acc       <= '0;
            r_rem       <= '0;
            r_idlen     <= '0;
            r_plen      <= '0;
            r_bid       <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_type      <= n_type;
                r_fbc       <= n_fbc;
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_idlen     <= n_idlen;
                r_plen      <= n_plen;
                r_bid       <= n_bid;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result beat payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_status <= n_status;
            r_out_kind   <= n_kind;
            r_out_type   <= n_type;
            r_out_byte   <= din;
            r_out_idlen  <= n_idlen;
            r_out_plen   <= n_plen;
            r_out_bid    <= n_bid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{ambp_pkg::OUT_PAD_W{1'b0}}, r_out_bid, r_out_plen, r_out_idlen,
                            r_out_byte, r_out_type, r_out_status};

    // Checks
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_status != ambp_pkg::ST_BUSY) |=> (r_phase == PH_HEADER))
        else $error("parser did not return to header after done or error");

    a_header_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == ambp_pkg::KIND_HEADER) |->
        (r_out_idlen == '0 && r_out_plen == '0 && r_out_bid == '0))
        else $error("header beat carries stale message fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == ambp_pkg::ST_BUSY ||
                         r_out_status == ambp_pkg::ST_DONE ||
                         r_out_status == ambp_pkg::ST_ERR))
        else $error("result beat carries an undefined status");

    a_idlen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLEN) |-> (r_fbc == 3'd0 || r_fbc == 3'd1))
        else $error("id length byte count out of range");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_ID) |-> (r_rem != '0))
        else $error("countdown phase entered with nothing left");

endmodule

@@ verif/agent_message_byte_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Agent message byte parser - self-checking testbench
// Streams header, id, payload and bundle bytes into the parser and checks
// every result beat against a cycle-free parser model held in the bench.
// A short table of directed bytes comes first. Randomly built messages
// follow, some cut short and followed by stray bytes, across several
// payload limits. Sender bursts and receiver stalls vary all the time.
// ----------------------------------------------------------------------------
module agent_message_byte_parser_unit_tb;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned PHASE_BYTES = 60;
    localparam int unsigned MAX_PRINTS  = 40;

    // Model phases of the message being parsed
    typedef enum logic [2:0] {
        PARSE_HEADER,
        PARSE_IDLEN,
        PARSE_ID,
        PARSE_PLEN,
        PARSE_PAYLOAD,
        PARSE_BUNDLE
    } t_parse_phase;

    // Receiver ready patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_QUARTER,
        RX_SPARSE
    } t_rx_mode;

    // One tagged byte as the parser reports it
    typedef struct {
        ambp_pkg::t_status status;
        logic [3:0]        msg_type;
        ambp_pkg::t_kind   kind;
        logic [7:0]        data;
        logic [15:0]       id_len;
        logic [63:0]       pay_len;
        logic [63:0]       bundle;
    } t_tag;

    // One directed byte; tag is used in place of the model when typed is set
    typedef struct {
        logic [7:0]  data;
        bit          typed;
        t_tag        tag;
        bit          set_limit;
        logic [63:0] limit;
    } t_dir_row;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [ambp_pkg::LEN64_W-1:0]  i_cfg_wdata   = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ambp_pkg::BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ambp_pkg::OUT_W-1:0]    m_axis_tdata;
    logic [ambp_pkg::KIND_W-1:0]   m_axis_tuser;

    // Model state and its copy of the payload limit
    t_parse_phase p_phase = PARSE_HEADER;
    logic [3:0]   p_type  = '0;
    logic [2:0]   p_count = '0;
    logic [63:0]  p_acc   = '0;
    logic [63:0]  p_left  = '0;
    logic [15:0]  p_idlen = '0;
    logic [63:0]  p_plen  = '0;
    logic [63:0]  p_bid   = '0;
    logic [63:0]  limit_q = '0;

    t_tag        pending_tags[$];
    t_dir_row    dir_rows[$];
    t_tag        head_tag;
    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned idle_cycles = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_span     = 0;

    agent_message_byte_parser_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Advance the parser model by one byte and return its tag
    function automatic t_tag tag_byte(input logic [7:0] b);
        t_tag              r;
        ambp_pkg::t_status st;
        st     = ambp_pkg::ST_BUSY;
        r.kind = ambp_pkg::KIND_HEADER;
        case (p_phase)
            PARSE_HEADER: begin
                // clear every per-message register on a new header
                p_type  = b[3:0];
                p_count = '0;
                p_acc   = '0;
                p_left  = '0;
                p_idlen = '0;
                p_plen  = '0;
                p_bid   = '0;
                if (b[7:4] != ambp_pkg::HDR_VERSION) begin
                    st = ambp_pkg::ST_ERR;
                end else begin
                    case (p_type)
                        ambp_pkg::MT_ACK, ambp_pkg::MT_NACK, ambp_pkg::MT_PING:
                            st = ambp_pkg::ST_DONE;
                        ambp_pkg::MT_REGISTER, ambp_pkg::MT_SEND,
                        ambp_pkg::MT_RECV, ambp_pkg::MT_WELCOME:
                            p_phase = PARSE_IDLEN;
                        ambp_pkg::MT_CONFIRM, ambp_pkg::MT_CANCEL:
                            p_phase = PARSE_BUNDLE;
                        default:
                            st = ambp_pkg::ST_ERR;
                    endcase
                end
            end
            PARSE_IDLEN: begin
                r.kind  = ambp_pkg::KIND_IDLEN;
                p_idlen = {p_idlen[7:0], b};
                if (p_count == 0) begin
                    p_count = 1;
                end else begin
                    p_count = 0;
                    p_left  = {48'd0, p_idlen};
                    if (p_idlen == 0)
                        st = ambp_pkg::ST_DONE;
                    else
                        p_phase = PARSE_ID;
                end
            end
            PARSE_ID: begin
                r.kind = ambp_pkg::KIND_ID;
                if (p_left != 0)
                    p_left--;
                if (p_left == 0) begin
                    if (p_type == ambp_pkg::MT_SEND || p_type == ambp_pkg::MT_RECV) begin
                        p_phase = PARSE_PLEN;
                        p_count = 0;
                        p_acc   = '0;
                    end else begin
                        st = ambp_pkg::ST_DONE;
                    end
                end
            end
            PARSE_PLEN: begin
                r.kind = ambp_pkg::KIND_PLEN;
                p_acc  = {p_acc[55:0], b};
                if (p_count < 7) begin
                    p_count++;
                end else begin
                    p_count = 0;
                    p_plen  = p_acc;
                    p_left  = p_acc;
                    if (limit_q != 0 && p_plen > limit_q)
                        st = ambp_pkg::ST_ERR;
                    else if (p_plen == 0)
                        st = ambp_pkg::ST_DONE;
                    else
                        p_phase = PARSE_PAYLOAD;
                end
            end
            PARSE_PAYLOAD: begin
                r.kind = ambp_pkg::KIND_PAYLOAD;
                if (p_left != 0)
                    p_left--;
                if (p_left == 0)
                    st = ambp_pkg::ST_DONE;
            end
            default: begin
                r.kind = ambp_pkg::KIND_BUNDLE;
                p_acc  = {p_acc[55:0], b};
                if (p_count < 7) begin
                    p_count++;
                end else begin
                    p_count = 0;
                    p_bid   = p_acc;
                    st      = ambp_pkg::ST_DONE;
                end
            end
        endcase
        if (st != ambp_pkg::ST_BUSY)
            p_phase = PARSE_HEADER;
        r.status   = st;
        r.msg_type = p_type;
        r.data     = b;
        r.id_len   = p_idlen;
        r.pay_len  = p_plen;
        r.bundle   = p_bid;
        return r;
    endfunction

    // Pick a byte that keeps any length small; wild leaves low length bytes free
    function automatic logic [7:0] filler_byte(input bit wild);
        case (p_phase)
            PARSE_IDLEN:
                return (p_count == 0) ? 8'h00
                       : (wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)));
            PARSE_PLEN:
                return (p_count < 7) ? 8'h00
                       : (wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12)));
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // Offer one byte; gaps between bursts are taken before the beat is raised
    task automatic send_byte(input logic [7:0] b);
        if (gap_left != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        pending_tags.push_back(tag_byte(b));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    // Hold the input side idle until every result beat has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_tags.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [63:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_q = v;
    endtask

    task automatic add_row(input logic [7:0] data, input bit typed = 1'b0,
                           input ambp_pkg::t_status st = ambp_pkg::ST_BUSY,
                           input logic [3:0] mt = ambp_pkg::MT_ACK,
                           input ambp_pkg::t_kind kind = ambp_pkg::KIND_HEADER,
                           input logic [15:0] idlen = '0, input logic [63:0] plen = '0,
                           input logic [63:0] bid = '0, input bit set_limit = 1'b0,
                           input logic [63:0] limit = '0);
        t_dir_row r;
        r.data         = data;
        r.typed        = typed;
        r.tag.status   = st;
        r.tag.msg_type = mt;
        r.tag.kind     = kind;
        r.tag.data     = data;
        r.tag.id_len   = idlen;
        r.tag.pay_len  = plen;
        r.tag.bundle   = bid;
        r.set_limit    = set_limit;
        r.limit        = limit;
        dir_rows.push_back(r);
    endtask

    // Build one random message, maybe cut it short and add stray bytes,
    // then close whatever the parser still waits for
    task automatic send_message();
        logic [7:0]  msg[$];
        logic [3:0]  mt;
        logic [3:0]  hi;
        logic [15:0] idlen;
        logic [63:0] plen;
        logic [63:0] bid;
        int          pick;
        int          cut;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // header with a wrong version or a type past ping
            if ($urandom_range(0, 1) == 0) begin
                hi = 4'($urandom_range(0, 14));
                if (hi >= ambp_pkg::HDR_VERSION)
                    hi++;
                msg.push_back({hi, 4'($urandom_range(0, 15))});
            end else begin
                msg.push_back({ambp_pkg::HDR_VERSION, 4'($urandom_range(9, 15))});
            end
        end else begin
            mt = 4'($urandom_range(0, 8));
            msg.push_back({ambp_pkg::HDR_VERSION, mt});
            case (mt)
                ambp_pkg::MT_REGISTER, ambp_pkg::MT_SEND,
                ambp_pkg::MT_RECV, ambp_pkg::MT_WELCOME: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        idlen = '0;
                    else if (pick < 20)
                        idlen = 16'(256 + $urandom_range(0, 40));
                    else
                        idlen = 16'($urandom_range(1, 8));
                    msg.push_back(idlen[15:8]);
                    msg.push_back(idlen[7:0]);
                    repeat (idlen) msg.push_back(8'($urandom));
                    if ((mt == ambp_pkg::MT_SEND || mt == ambp_pkg::MT_RECV) && idlen != 0) begin
                        if (limit_q != 0 && limit_q != '1 && $urandom_range(0, 3) == 0)
                            plen = limit_q + 64'd1 + ({$urandom, $urandom} % (~limit_q));
                        else if (limit_q != 0 && limit_q <= 24 && $urandom_range(0, 3) == 0)
                            plen = limit_q;
                        else if ($urandom_range(0, 6) == 0)
                            plen = '0;
                        else
                            plen = 64'($urandom_range(1, 24));
                        for (int i = 7; i >= 0; i--)
                            msg.push_back(plen[i*8 +: 8]);
                        if (plen != 0 && (limit_q == 0 || plen <= limit_q))
                            repeat (plen) msg.push_back(8'($urandom));
                    end
                end
                ambp_pkg::MT_CONFIRM, ambp_pkg::MT_CANCEL: begin
                    bid = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
                    for (int i = 7; i >= 0; i--)
                        msg.push_back(bid[i*8 +: 8]);
                end
                default: ;
            endcase
        end

        // cut about one message in seven, never inside a payload length
        cut = msg.size();
        if (msg.size() > 1 && $urandom_range(0, 6) == 0)
            cut = $urandom_range(1, msg.size() - 1);
        foreach (msg[i]) begin
            if (i >= cut && !(p_phase == PARSE_PLEN && p_count != 0))
                break;
            send_byte(msg[i]);
        end
        if (cut < msg.size())
            repeat ($urandom_range(1, 4)) send_byte(filler_byte(1'b1));
        while (p_phase != PARSE_HEADER)
            send_byte(filler_byte(1'b0));
    endtask

    // Vary the receiver: always ready, coin flips, one in four, rare
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_span = $urandom_range(20, 200);
        end else begin
            rx_span--;
        end
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_axis_tready <= (rx_span % 4 == 0);
            default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each result beat with the oldest expected tag
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_tags.size() == 0) begin
                report_mismatch("result beat with nothing expected", '0, '0);
            end else begin
                head_tag = pending_tags.pop_front();
                if (m_axis_tdata[1:0] !== head_tag.status)
                    report_mismatch("status", m_axis_tdata[1:0], head_tag.status);
                if (m_axis_tdata[5:2] !== head_tag.msg_type)
                    report_mismatch("msg_type", m_axis_tdata[5:2], head_tag.msg_type);
                if (m_axis_tuser !== head_tag.kind)
                    report_mismatch("byte_kind", m_axis_tuser, head_tag.kind);
                if (m_axis_tdata[13:6] !== head_tag.data)
                    report_mismatch("byte_out", m_axis_tdata[13:6], head_tag.data);
                if (m_axis_tdata[29:14] !== head_tag.id_len)
                    report_mismatch("id_length", m_axis_tdata[29:14], head_tag.id_len);
                if (m_axis_tdata[93:30] !== head_tag.pay_len)
                    report_mismatch("pay_len", m_axis_tdata[93:30], head_tag.pay_len);
                if (m_axis_tdata[157:94] !== head_tag.bundle)
                    report_mismatch("bund_id", m_axis_tdata[157:94], head_tag.bundle);
            end
        end
    end

    // End the run when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned start;
        logic [63:0] lim;

        // headers alone: done types, bad versions, unknown types
        add_row(8'h10, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_ACK, ambp_pkg::KIND_HEADER);
        add_row(8'h11, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_NACK, ambp_pkg::KIND_HEADER);
        add_row(8'h18, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_PING, ambp_pkg::KIND_HEADER);
        add_row(8'h00, 1, ambp_pkg::ST_ERR, 4'h0, ambp_pkg::KIND_HEADER);
        add_row(8'hFF, 1, ambp_pkg::ST_ERR, 4'hF, ambp_pkg::KIND_HEADER);
        add_row(8'h19, 1, ambp_pkg::ST_ERR, 4'h9, ambp_pkg::KIND_HEADER);
        add_row(8'h1F, 1, ambp_pkg::ST_ERR, 4'hF, ambp_pkg::KIND_HEADER);
        // zero id length ends each of the four id-carrying types
        add_row(8'h12, 1, ambp_pkg::ST_BUSY, ambp_pkg::MT_REGISTER, ambp_pkg::KIND_HEADER);
        add_row(8'h00, 1, ambp_pkg::ST_BUSY, ambp_pkg::MT_REGISTER, ambp_pkg::KIND_IDLEN);
        add_row(8'h00, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_REGISTER, ambp_pkg::KIND_IDLEN);
        add_row(8'h17, 1, ambp_pkg::ST_BUSY, ambp_pkg::MT_WELCOME, ambp_pkg::KIND_HEADER);
        add_row(8'h00);
        add_row(8'h00, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_WELCOME, ambp_pkg::KIND_IDLEN);
        add_row(8'h13);
        add_row(8'h00);
        add_row(8'h00, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_SEND, ambp_pkg::KIND_IDLEN);
        add_row(8'h14);
        add_row(8'h00);
        add_row(8'h00, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_RECV, ambp_pkg::KIND_IDLEN);
        // all-ones bundle id
        add_row(8'h15, 1, ambp_pkg::ST_BUSY, ambp_pkg::MT_CONFIRM, ambp_pkg::KIND_HEADER);
        repeat (7) add_row(8'hFF);
        add_row(8'hFF, 1, ambp_pkg::ST_DONE, ambp_pkg::MT_CONFIRM, ambp_pkg::KIND_BUNDLE,
                16'd0, 64'd0, '1);
        // largest payload length against a limit of one
        add_row(8'h14, 1, ambp_pkg::ST_BUSY, ambp_pkg::MT_RECV, ambp_pkg::KIND_HEADER,
                16'd0, 64'd0, 64'd0, 1, 64'd1);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h5A);
        repeat (7) add_row(8'hFF);
        add_row(8'hFF, 1, ambp_pkg::ST_ERR, ambp_pkg::MT_RECV, ambp_pkg::KIND_PLEN,
                16'd1, '1, 64'd0);

        // hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_limit)
                write_limit(dir_rows[i].limit);
            send_byte(dir_rows[i].data);
            if (dir_rows[i].typed)
                pending_tags[pending_tags.size() - 1] = dir_rows[i].tag;
        end

        // random messages under a run of payload limits
        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                case (ph)
                    1:       lim = '1;
                    2:       lim = 64'($urandom_range(2, 40));
                    3:       lim = 64'd0;
                    4:       lim = {$urandom, $urandom};
                    default: lim = 64'($urandom_range(3, 12));
                endcase
                write_limit(lim);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_message();
        end

        // let the last beats out and catch any extra ones
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
